[rtl/core/adjacency_bit_matrix_defines.svh]
// Assertion macros for the adjacency bit matrix checker.
`ifndef ADJACENCY_BIT_MATRIX_DEFINES_SVH
`define ADJACENCY_BIT_MATRIX_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ABM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abm assertion failed");

// Next-cycle implication, disabled during reset.
`define ABM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abm assertion failed");

`endif

[rtl/core/abm_pkg.sv]
package abm_pkg;

  localparam int NODES  = 32;
  localparam int IDX_W  = $clog2(NODES);
  localparam int SIZE_W = IDX_W + 1;
  localparam int ROW_W  = NODES;

  localparam logic [ROW_W-1:0]  FULL_ROW = 32'hFFFFFFFF;
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(NODES);

  localparam logic [1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [1:0] CFG_COLS_IN_USE = 2'd1;

  typedef enum logic [2:0] {
    KIND_CONNECT        = 3'd0,
    KIND_DISCONNECT     = 3'd1,
    KIND_CONNECT_ALL    = 3'd2,
    KIND_DISCONNECT_ALL = 3'd3,
    KIND_QUERY          = 3'd4,
    KIND_FIND_SINK      = 3'd5,
    KIND_FIND_SOURCE    = 3'd6,
    KIND_NOP            = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_FILL,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic             set_bit;
    logic             clr_bit;
    logic             or_row;
    logic             clr_all;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] bit_sel;
    logic [ROW_W-1:0] mask;
  } mat_cmd_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
    return (v > SIZE_MAX) ? SIZE_MAX : v;
  endfunction

endpackage

[rtl/core/abm_matrix.sv]
module abm_matrix (
  input  logic                            clk,
  input  logic                            rst,
  input  abm_pkg::mat_cmd_t               cmd,
  input  logic [abm_pkg::IDX_W-1:0]       rd_addr,
  output logic [abm_pkg::ROW_W-1:0]       rd_row
);
  import abm_pkg::*;

  logic [ROW_W-1:0] adj [NODES];

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      for (int i = 0; i < NODES; i++) begin
        adj[i] <= '0;
      end
    end else if (cmd.set_bit) begin
      adj[cmd.addr][cmd.bit_sel] <= 1'b1;
    end else if (cmd.clr_bit) begin
      adj[cmd.addr][cmd.bit_sel] <= 1'b0;
    end else if (cmd.or_row) begin
      adj[cmd.addr] <= adj[cmd.addr] | cmd.mask;
    end
  end

  assign rd_row = adj[rd_addr];

endmodule

[rtl/core/abm_seq.sv]
module abm_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [2:0]                      kind,
  input  logic [abm_pkg::IDX_W-1:0]       row_index,
  input  logic [abm_pkg::IDX_W-1:0]       col_index,
  input  logic [abm_pkg::SIZE_W-1:0]      rows_in_use,
  input  logic [abm_pkg::SIZE_W-1:0]      cols_in_use,
  input  logic [abm_pkg::ROW_W-1:0]       rd_row,
  output abm_pkg::mat_cmd_t               cmd,
  output logic [abm_pkg::IDX_W-1:0]       rd_addr,
  output logic                            busy,
  output logic                            done,
  output logic                            connected,
  output logic                            found,
  output logic [abm_pkg::IDX_W-1:0]       found_index,
  output logic                            index_error
);
  import abm_pkg::*;

  state_t           state, state_next;
  kind_t            op, op_next;
  logic [IDX_W-1:0] row_q, row_q_next;
  logic [IDX_W-1:0] col_q, col_q_next;
  logic             err, err_next;
  logic [IDX_W-1:0] idx, idx_next;

  logic             done_next, connected_next, found_next, index_error_next;
  logic [IDX_W-1:0] found_index_next;

  kind_t            kind_in;
  logic             in_range;
  logic             indexed;
  logic [IDX_W-1:0] bit_sel;
  logic             hit;
  logic [ROW_W-1:0] col_mask;

  assign kind_in  = kind_t'(kind);
  assign in_range = ({1'b0, row_index} < rows_in_use) && ({1'b0, col_index} < cols_in_use);
  assign indexed  = (kind_in == KIND_CONNECT) || (kind_in == KIND_DISCONNECT) ||
                    (kind_in == KIND_QUERY) || (kind_in == KIND_FIND_SINK) ||
                    (kind_in == KIND_FIND_SOURCE);
  assign col_mask = cols_in_use[IDX_W] ? FULL_ROW
                  : ((ROW_W'(1) << cols_in_use[IDX_W-1:0]) - ROW_W'(1));
  assign hit      = rd_row[bit_sel];
  assign busy     = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      connected   <= 1'b0;
      found       <= 1'b0;
      found_index <= '0;
      index_error <= 1'b0;
    end else begin
      state       <= state_next;
      done        <= done_next;
      connected   <= connected_next;
      found       <= found_next;
      found_index <= found_index_next;
      index_error <= index_error_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    row_q <= row_q_next;
    col_q <= col_q_next;
    err   <= err_next;
    idx   <= idx_next;
  end

  always_comb begin
    state_next       = state;
    op_next          = op;
    row_q_next       = row_q;
    col_q_next       = col_q;
    err_next         = err;
    idx_next         = idx;
    done_next        = 1'b0;
    connected_next   = 1'b0;
    found_next       = 1'b0;
    found_index_next = '0;
    index_error_next = 1'b0;
    rd_addr          = row_q;
    bit_sel          = col_q;
    cmd              = '0;
    cmd.addr         = row_q;
    cmd.bit_sel      = col_q;
    cmd.mask         = col_mask;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_next    = kind_in;
          row_q_next = row_index;
          col_q_next = col_index;
          err_next   = indexed && !in_range;
          if (kind_in == KIND_CONNECT_ALL && rows_in_use != '0) begin
            idx_next   = '0;
            state_next = ST_FILL;
          end else if ((kind_in == KIND_FIND_SINK || kind_in == KIND_FIND_SOURCE)
                       && in_range) begin
            idx_next   = (kind_in == KIND_FIND_SINK) ? col_index : row_index;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_SINGLE;
          end
        end
      end
      ST_SINGLE: begin
        done_next        = 1'b1;
        index_error_next = err;
        state_next       = ST_IDLE;
        unique case (op)
          KIND_CONNECT:        cmd.set_bit = !err;
          KIND_DISCONNECT:     cmd.clr_bit = !err;
          KIND_DISCONNECT_ALL: cmd.clr_all = 1'b1;
          KIND_QUERY:          connected_next = !err && hit;
          default: ;
        endcase
      end
      ST_FILL: begin
        cmd.or_row = 1'b1;
        cmd.addr   = idx;
        if ({1'b0, idx} == rows_in_use - SIZE_W'(1)) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      ST_SCAN: begin
        rd_addr = (op == KIND_FIND_SINK) ? row_q : idx;
        bit_sel = (op == KIND_FIND_SINK) ? idx : col_q;
        if (hit) begin
          done_next        = 1'b1;
          found_next       = 1'b1;
          found_index_next = idx;
          state_next       = ST_IDLE;
        end else if (idx == '0) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx - IDX_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/adjacency_bit_matrix.sv]
// Adjacency bit matrix: 32 x 32 directed edges, bit (row, col) = edge row -> col.
// Request channel: start with kind, row_index, col_index; transfer when start
// is high and busy is low. busy stays high until the request's result is out.
// Result channel: done pulses for one cycle with connected, found, found_index
// and index_error; the receiver cannot stall, so every result is taken then.
// Other cycles show zero on the result fields.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 rows, 1 cols) and
// cfg_data; cfg_ready is low while busy; values above 32 saturate to 32.
// Sequence from accepting start to done:
//   connect, disconnect, query, disconnect all, errors: the single-step state
//   connect all: one row ORed per cycle; the single-step state if no rows
//   find sink / find source: one matrix bit tested per cycle by the shared
//   scan step, from the start index downward.
// A new request may be accepted in the cycle done is high.
// Reset (rst, synchronous) clears all edges, sets both sizes to 32 and
// returns the sequencer to idle.
module adjacency_bit_matrix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    kind,
  input  logic [abm_pkg::IDX_W-1:0]     row_index,
  input  logic [abm_pkg::IDX_W-1:0]     col_index,
  output logic                          done,
  output logic                          connected,
  output logic                          found,
  output logic [abm_pkg::IDX_W-1:0]     found_index,
  output logic                          index_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [abm_pkg::SIZE_W-1:0]    cfg_data
);
  import abm_pkg::*;

  logic [SIZE_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] cols_in_use;
  mat_cmd_t          cmd;
  logic [IDX_W-1:0]  rd_addr;
  logic [ROW_W-1:0]  rd_row;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= SIZE_MAX;
      cols_in_use <= SIZE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ROWS_IN_USE) begin
        rows_in_use <= clamp_size(cfg_data);
      end else if (cfg_index == CFG_COLS_IN_USE) begin
        cols_in_use <= clamp_size(cfg_data);
      end
    end
  end

  abm_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .rd_row  (rd_row)
  );

  abm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .kind        (kind),
    .row_index   (row_index),
    .col_index   (col_index),
    .rows_in_use (rows_in_use),
    .cols_in_use (cols_in_use),
    .rd_row      (rd_row),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .busy        (busy),
    .done        (done),
    .connected   (connected),
    .found       (found),
    .found_index (found_index),
    .index_error (index_error)
  );

endmodule

[rtl/core/abm_checker.sv]
`include "adjacency_bit_matrix_defines.svh"

module abm_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       connected,
  input logic       found,
  input logic [4:0] found_index,
  input logic       index_error
);

  `ABM_ASSERT_NEXT(a_start_goes_busy, clk, rst, start && !busy, busy)
  `ABM_ASSERT_IMPL(a_done_when_idle, clk, rst, done, !busy)
  `ABM_ASSERT_IMPL(a_quiet_outputs, clk, rst, !done, {connected, found, found_index, index_error} == '0)
  `ABM_ASSERT_IMPL(a_error_excludes_hit, clk, rst, done && index_error, !found && !connected)
  `ABM_ASSERT_NEXT(a_done_single_pulse, clk, rst, done && !start, !done)

endmodule

bind adjacency_bit_matrix abm_checker u_abm_checker (.*);
